// File: src/gwpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwpc_pkg
// Shared types and constants of the gyro window path classifier.
// ----------------------------------------------------------------------------
package gwpc_pkg;

  localparam int DEF_RING_DEPTH  = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_LEN_W = 6;
  localparam int THRESH_W  = 15;
  localparam int AVG_W     = 15;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [CFG_LEN_W-1:0] JUDGE_LEN_RST  = 6'd32;
  localparam logic [CFG_LEN_W-1:0] NORMAL_LEN_RST = 6'd16;
  localparam logic [THRESH_W-1:0]  THRESH_RST     = 15'd1000;

  typedef enum logic [1:0] {
    REG_JUDGE  = 2'd0,
    REG_NORMAL = 2'd1,
    REG_THRESH = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    PATH_UNKNOWN   = 2'd0,
    PATH_STRAIGHT  = 2'd1,
    PATH_LEFT_BEND = 2'd2
  } path_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SUB,
    S_PUSH,
    S_DIV,
    S_WAIT,
    S_OUT
  } seq_e;

  typedef struct packed {
    logic [CFG_LEN_W-1:0] judge_len;
    logic [CFG_LEN_W-1:0] normal_len;
    logic [THRESH_W-1:0]  threshold;
  } cfg_t;

endpackage

// File: src/gwpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwpc_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gwpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/gwpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwpc_div
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module gwpc_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    den_d   = den_q;
    shifted = {rem_q, quot_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quot_d = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DEN_W]) begin
        rem_d  = diff[DEN_W-1:0];
        quot_d = {quot_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted[DEN_W-1:0];
        quot_d = {quot_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: src/gwpc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwpc_regs
// APB-style configuration registers: window lengths and turn threshold.
// ----------------------------------------------------------------------------
module gwpc_regs
  import gwpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign idx    = reg_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_JUDGE:  cfg_d.judge_len  = pwdata[CFG_LEN_W-1:0];
        REG_NORMAL: cfg_d.normal_len = pwdata[CFG_LEN_W-1:0];
        REG_THRESH: cfg_d.threshold  = pwdata[THRESH_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_JUDGE:  prdata = PDATA_W'(cfg_q.judge_len);
      REG_NORMAL: prdata = PDATA_W'(cfg_q.normal_len);
      REG_THRESH: prdata = PDATA_W'(cfg_q.threshold);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.judge_len  <= JUDGE_LEN_RST;
      cfg_q.normal_len <= NORMAL_LEN_RST;
      cfg_q.threshold  <= THRESH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/gyro_window_path_classifier.sv
`timescale 1ns / 1ps
// Takes one signed gyro item at a time and returns one result item per input:
// the truncated mean of the absolute samples held in the window and the path
// class after the update. One item at a time is processed. The running sum is
// SUM_W = SAMPLE_BITS - 1 + clog2(RING_DEPTH) bits wide (21 at the defaults).
// For each item the old entries beyond the window length are dropped first
// (usually one once the window is full), then the serial divider, one quotient
// bit per cycle, forms the mean. Each dropped entry costs a read of the ring
// RAM and a subtract.
// A new item is taken while the previous result still waits at the output.
// ----------------------------------------------------------------------------
// gyro_window_path_classifier
// Sliding-window mean of gyro magnitudes with a three-state path classifier.
// ----------------------------------------------------------------------------
module gyro_window_path_classifier
  import gwpc_pkg::*;
#(
  parameter int RING_DEPTH  = DEF_RING_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] gyro_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    path_class_o,
  output logic [AVG_W-1:0]              window_average_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  localparam int MAG_W  = SAMPLE_BITS - 1;
  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH);
  localparam int SUM_W  = MAG_W + FILL_W;
  localparam int CMP_W  = MAG_W + THRESH_W;

  cfg_t cfg;

  seq_e              state_q, state_d;
  path_e             path_q, path_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [FILL_W-1:0] len_q, len_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [MAG_W-1:0]  avg_q, avg_d;
  logic              out_valid_q, out_valid_d;
  path_e             out_path_q, out_path_d;
  logic [AVG_W-1:0]  out_avg_q, out_avg_d;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_addr;
  logic [MAG_W-1:0]       ram_rdata;
  logic                   div_start, div_done;
  logic [SUM_W-1:0]       div_quot;
  logic [SAMPLE_BITS-1:0] raw, neg;
  logic [MAG_W-1:0]       mag_in;
  logic [CFG_LEN_W-1:0]   len_raw;
  logic [FILL_W-1:0]      len_in;
  logic [CMP_W-1:0]       avg_x, thr_x;
  logic [SUM_W+AVG_W-1:0] avg_wide;
  logic                   in_acc;

  gwpc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  gwpc_ram #(
    .WIDTH(MAG_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(mag_q),
    .rdata_o(ram_rdata)
  );

  gwpc_div #(
    .NUM_W(SUM_W),
    .DEN_W(FILL_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (fill_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // magnitude, saturating at the most negative sample
  always_comb begin
    raw = $unsigned(gyro_sample_i);
    neg = ~raw + 1'b1;
    if (!raw[SAMPLE_BITS-1]) begin
      mag_in = raw[MAG_W-1:0];
    end else if (raw == {1'b1, {MAG_W{1'b0}}}) begin
      mag_in = {MAG_W{1'b1}};
    end else begin
      mag_in = neg[MAG_W-1:0];
    end
  end

  always_comb begin
    len_raw = (path_q == PATH_UNKNOWN) ? cfg.judge_len : cfg.normal_len;
    if (len_raw == '0) begin
      len_in = FILL_W'(1);
    end else if (32'(len_raw) > RING_DEPTH - 1) begin
      len_in = FILL_W'(RING_DEPTH - 1);
    end else begin
      len_in = FILL_W'(len_raw);
    end
  end

  assign avg_x    = {{THRESH_W{1'b0}}, avg_q};
  assign thr_x    = {{MAG_W{1'b0}}, cfg.threshold};
  assign avg_wide = {{AVG_W{1'b0}}, SUM_W'(avg_q)};
  assign in_acc   = in_valid_i & in_ready_o;

  always_comb begin
    state_d     = state_q;
    path_d      = path_q;
    mag_d       = mag_q;
    len_d       = len_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_path_d  = out_path_q;
    out_avg_d   = out_avg_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = head_q;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mag_d   = mag_in;
          len_d   = len_in;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (fill_q >= len_q) begin
          ram_re  = 1'b1;
          state_d = S_SUB;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_SUB: begin
        sum_d   = sum_q - SUM_W'(ram_rdata);
        head_d  = (head_q == IDX_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
        fill_d  = fill_q - 1'b1;
        state_d = S_CHECK;
      end
      S_PUSH: begin
        ram_we   = 1'b1;
        ram_addr = tail_q;
        tail_d   = (tail_q == IDX_W'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
        fill_d   = fill_q + 1'b1;
        sum_d    = sum_q + SUM_W'(mag_q);
        state_d  = S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          avg_d   = div_quot[MAG_W-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          unique case (path_q)
            PATH_UNKNOWN: begin
              if (fill_q >= len_q) begin
                path_d = (avg_x > thr_x) ? PATH_LEFT_BEND : PATH_STRAIGHT;
              end
            end
            PATH_STRAIGHT:  if (avg_x > thr_x) path_d = PATH_UNKNOWN;
            PATH_LEFT_BEND: if (avg_x < thr_x) path_d = PATH_UNKNOWN;
            default:        path_d = PATH_UNKNOWN;
          endcase
          out_valid_d = 1'b1;
          out_path_d  = path_d;
          out_avg_d   = avg_wide[AVG_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      path_q      <= PATH_UNKNOWN;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      path_q      <= path_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    len_q      <= len_d;
    avg_q      <= avg_d;
    out_path_q <= out_path_d;
    out_avg_q  <= out_avg_d;
  end

  assign out_valid_o      = out_valid_q;
  assign path_class_o     = out_path_q;
  assign window_average_o = out_avg_q;

  // ring occupancy agrees with the head and tail pointers between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      (32'(fill_q) == ((tail_q >= head_q) ? 32'(tail_q) - 32'(head_q)
                                          : 32'(tail_q) + RING_DEPTH - 32'(head_q))))
    else $error("ring pointers and fill count disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (fill_q != '0) && (fill_q <= len_q))
    else $error("window holds more entries than its length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_OUT) |=> (path_q == $past(path_q)))
    else $error("path state changed outside result stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_CHECK) && !in_ready_o)
    else $error("accepted item did not start processing");

endmodule

// File: bench/gyro_window_path_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_window_path_classifier_test
// Self-checking bench for the gyro window path classifier. A scoreboard
// class keeps its own copy of the magnitude ring, running sum and path state.
// It predicts the class and the average for every accepted gyro item and
// checks each result item in order. Plain tasks drive the sample channel and
// the APB port. The run uses directed items at the window and threshold
// edges, then bursts of low, high, near-threshold, full-range and extreme
// samples under several register settings. Both sides idle at random.
// ----------------------------------------------------------------------------
module gyro_window_path_classifier_test;
  import gwpc_pkg::*;

  localparam int                 RING      = DEF_RING_DEPTH;
  localparam int                 SBITS     = DEF_SAMPLE_BITS;
  localparam logic [PADDR_W-1:0] ADDR_NONE = 4'd12;

  typedef struct packed {
    path_e             cls;
    logic [AVG_W-1:0]  avg;
  } path_result_t;

  class path_scoreboard;
    logic [14:0]          mag_ring [RING];
    logic [5:0]           head;
    logic [5:0]           tail;
    logic [6:0]           fill;
    logic [20:0]          sum;
    path_e                state;
    logic [CFG_LEN_W-1:0] judge_len;
    logic [CFG_LEN_W-1:0] normal_len;
    logic [THRESH_W-1:0]  threshold;
    path_result_t         expected_results [$];
    int                   errors;
    int                   checked;
    int                   class_seen [3];

    function new();
      foreach (mag_ring[k]) mag_ring[k] = '0;
      head       = '0;
      tail       = '0;
      fill       = '0;
      sum        = '0;
      state      = PATH_UNKNOWN;
      judge_len  = JUDGE_LEN_RST;
      normal_len = NORMAL_LEN_RST;
      threshold  = THRESH_RST;
      errors     = 0;
      checked    = 0;
      foreach (class_seen[k]) class_seen[k] = 0;
    endfunction

    function void apply_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      if (addr[1:0] == 2'b00) begin
        case (reg_e'(addr[3:2]))
          REG_JUDGE:  judge_len  = data[CFG_LEN_W-1:0];
          REG_NORMAL: normal_len = data[CFG_LEN_W-1:0];
          REG_THRESH: threshold  = data[THRESH_W-1:0];
          default: ;
        endcase
      end
    endfunction

    function void note_sample(logic [SBITS-1:0] raw);
      logic [SBITS-1:0] neg;
      logic [14:0]      mag;
      int               len;
      int               avg;
      path_result_t     res;
      neg = -raw;
      if (!raw[SBITS-1]) mag = raw[14:0];
      else if (neg[SBITS-1]) mag = 15'h7FFF;   // most negative saturates
      else mag = neg[14:0];
      len = (state == PATH_UNKNOWN) ? int'(judge_len) : int'(normal_len);
      if (len < 1) len = 1;
      if (len > RING - 1) len = RING - 1;
      while (int'(fill) >= len && fill > 0) begin
        sum  = sum - mag_ring[head];
        head = head + 1'b1;
        fill = fill - 1'b1;
      end
      mag_ring[tail] = mag;
      tail = tail + 1'b1;
      fill = fill + 1'b1;
      sum  = sum + mag;
      avg  = int'(sum) / int'(fill);
      case (state)
        PATH_UNKNOWN: begin
          if (int'(fill) >= len)
            state = (avg > int'(threshold)) ? PATH_LEFT_BEND : PATH_STRAIGHT;
        end
        PATH_STRAIGHT: begin
          if (avg > int'(threshold)) state = PATH_UNKNOWN;
        end
        PATH_LEFT_BEND: begin
          if (avg < int'(threshold)) state = PATH_UNKNOWN;
        end
        default: state = PATH_UNKNOWN;
      endcase
      res.cls = state;
      res.avg = avg[AVG_W-1:0];
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [1:0] cls, logic [AVG_W-1:0] avg);
      path_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("unexpected result item: path_class %0d window_average %0d", cls, avg);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      checked++;
      if (cls < 3) class_seen[cls]++;
      if (cls !== exp_res.cls) begin
        $error("path_class: expected %0d, actual %0d", exp_res.cls, cls);
        errors++;
      end
      if (avg !== exp_res.avg) begin
        $error("window_average: expected %0d, actual %0d", exp_res.avg, avg);
        errors++;
      end
    endfunction

    function int pending_count();
      return expected_results.size();
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_ready_o;
  logic signed [SBITS-1:0] gyro_sample_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i   = 1'b0;
  logic [1:0]             path_class_o;
  logic [AVG_W-1:0]       window_average_o;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [PADDR_W-1:0]     paddr         = '0;
  logic [PDATA_W-1:0]     pwdata        = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  path_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int             items_sent = 0;
  int             settings_run = 1;

  gyro_window_path_classifier u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .gyro_sample_i    (gyro_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .path_class_o     (path_class_o),
    .window_average_o (window_average_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(path_class_o, window_average_o);
    out_ready_i <= no_idle || ($urandom_range(99) >= 15);
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_sample(input logic [SBITS-1:0] value);
    if (!no_idle && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!no_idle && $urandom_range(99) < 15);
    end
    in_valid_i    <= 1'b1;
    gyro_sample_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(value);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    sb.apply_write(addr, data);
  endtask

  task automatic set_window(input int judge, input int normal, input int thresh);
    drain_results();
    reg_write({REG_JUDGE, 2'b00}, PDATA_W'(judge));
    reg_write({REG_NORMAL, 2'b00}, PDATA_W'(normal));
    reg_write({REG_THRESH, 2'b00}, PDATA_W'(thresh));
    settings_run++;
  endtask

  function automatic logic [SBITS-1:0] signed_of(int mag);
    logic [SBITS-1:0] v;
    v = SBITS'(mag);
    return ($urandom_range(1) != 0) ? -v : v;
  endfunction

  // bursts of one kind of level so the mean settles above, below or at the threshold
  task automatic random_bursts(input int count, input int pause_at);
    int thr;
    int mode;
    int blen;
    int level;
    int lo;
    int hi;
    int done;
    logic [SBITS-1:0] value;
    thr  = int'(sb.threshold);
    done = 0;
    while (done < count) begin
      mode  = $urandom_range(99);
      blen  = $urandom_range(40, 1);
      lo    = (thr > 2) ? thr - 2 : 0;
      hi    = (thr < 32765) ? thr + 2 : 32767;
      level = $urandom_range(hi, lo);
      for (int k = 0; k < blen && done < count; k++) begin
        if (mode < 35) value = signed_of($urandom_range(thr, 0));
        else if (mode < 70) value = signed_of($urandom_range(32767, thr));
        else if (mode < 85) value = signed_of(level);
        else if (mode < 95) value = SBITS'($urandom);
        else begin
          case ($urandom_range(4))
            0: value = 16'h8000;
            1: value = 16'h7FFF;
            2: value = 16'h8001;
            3: value = 16'hFFFF;
            default: value = 16'h0000;
          endcase
        end
        send_sample(value);
        done++;
        if (done == pause_at) drain_results();
      end
    end
  endtask

  initial begin
    logic [SBITS-1:0] reset_items [10];
    logic [SBITS-1:0] edge_items [8];
    reset_items = '{16'h7FFF, 16'h8000, 16'h8001, 16'h0000, 16'hFFFF,
                    16'h0001, 16'h5555, 16'hAAAA, 16'd1000, -16'sd1000};
    edge_items  = '{16'd1000, 16'd1001, -16'sd1001, 16'd1000, 16'd999,
                    16'h8000, 16'h0000, 16'h0000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the window and threshold registers
    foreach (reset_items[k]) send_sample(reset_items[k]);
    random_bursts(100, 0);

    // length-one windows: every path transition, equality at the threshold
    set_window(1, 1, 1000);
    foreach (edge_items[k]) send_sample(edge_items[k]);

    // zero lengths written with upper garbage bits, zero threshold
    drain_results();
    reg_write({REG_JUDGE, 2'b00}, 32'hFFFF_FFC0);
    reg_write({REG_NORMAL, 2'b00}, 32'hA5A5_A5C0);
    reg_write({REG_THRESH, 2'b00}, 32'hFFFF_8000);
    settings_run++;
    random_bursts(105, 0);

    set_window(63, 63, 32767);
    random_bursts(105, 0);
    set_window(1, 63, 1000);
    random_bursts(105, 50);
    set_window(63, 1, 500);
    random_bursts(105, 0);

    set_window(4, 2, 2000);
    no_idle = 1'b1;
    random_bursts(105, 0);
    no_idle = 1'b0;

    set_window($urandom_range(63, 1), $urandom_range(63, 1), $urandom_range(32767));
    random_bursts(105, 0);

    set_window(8, 4, 100);
    reg_write(ADDR_NONE, 32'hFFFF_FFFF);
    random_bursts(105, 0);

    set_window(2, 3, 16384);
    random_bursts(105, 0);
    set_window($urandom_range(63, 1), $urandom_range(63, 1), $urandom_range(4000));
    random_bursts(105, 0);
    set_window(32, 16, 1000);
    random_bursts(100, 0);

    drain_results();
    repeat (200) @(posedge clk_i);
    if (sb.pending_count() != 0) begin
      $error("%0d expected result items never arrived", sb.pending_count());
      sb.errors++;
    end
    $display("Sent %0d gyro items under %0d register settings, checked %0d results",
             items_sent, settings_run, sb.checked);
    $display("Classes seen: unknown %0d, straight %0d, left bend %0d",
             sb.class_seen[0], sb.class_seen[1], sb.class_seen[2]);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
